/* hw/rtl/ptfl_pkg.sv */
// Package for the paged translation unit: request and result types, codes, constants.
// No dependencies.
package ptfl_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int MAX_PROCESSES_DEF = 8;
  localparam int PAGES_PER_PROCESS_DEF = 64;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_PSIZE = 2'd1;
  localparam logic [1:0] CFG_FRAMES = 2'd2;
  localparam logic [1:0] CFG_PROCS = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_BAD_PAGE = 2'd2;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_REINIT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [2:0]  process_slot;
    logic [15:0] virtual_address;
  } in_req_t;

  typedef struct packed {
    logic [14:0] physical_address;
    logic        page_fault;
    logic [2:0]  frame_number;
    logic [1:0]  status;
    logic [31:0] accesses_so_far;
    logic [31:0] faults_so_far;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CHECK, S_LOOKUP, S_SCAN, S_EVICT_RD, S_EVICT_WR, S_LOAD, S_HIT, S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_step;
    logic clear_start;
    logic lookup;
    logic scan_start;
    logic scan_step;
    logic evict_rd;
    logic evict_wr;
    logic load;
    logic hit;
    logic finish;
    logic err;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic reinit;
    logic bad;
    logic present;
    logic scan_done;
    logic clear_done;
    logic victim_occ;
  } stat_t;

endpackage

/* hw/rtl/ptfl_ctrl.sv */
// Controller state machine for the paged translation unit.
// Depends on ptfl_pkg.
module ptfl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ptfl_pkg::stat_t  stat,
  output ptfl_pkg::ctrl_t  ctrl
);

  ptfl_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ptfl_pkg::S_CLEAR;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptfl_pkg::S_IDLE: if (start) state_nxt = ptfl_pkg::S_CHECK;
      ptfl_pkg::S_CLEAR: if (stat.clear_done) state_nxt = ptfl_pkg::S_IDLE;
      ptfl_pkg::S_CHECK: begin
        if (stat.reinit) state_nxt = ptfl_pkg::S_CLEAR;
        else if (stat.bad) state_nxt = ptfl_pkg::S_DONE;
        else state_nxt = ptfl_pkg::S_LOOKUP;
      end
      ptfl_pkg::S_LOOKUP: state_nxt = stat.present ? ptfl_pkg::S_HIT : ptfl_pkg::S_SCAN;
      ptfl_pkg::S_SCAN: if (stat.scan_done)
        state_nxt = stat.victim_occ ? ptfl_pkg::S_EVICT_RD : ptfl_pkg::S_LOAD;
      ptfl_pkg::S_EVICT_RD: state_nxt = ptfl_pkg::S_EVICT_WR;
      ptfl_pkg::S_EVICT_WR: state_nxt = ptfl_pkg::S_LOAD;
      ptfl_pkg::S_LOAD: state_nxt = ptfl_pkg::S_DONE;
      ptfl_pkg::S_HIT: state_nxt = ptfl_pkg::S_DONE;
      ptfl_pkg::S_DONE: state_nxt = ptfl_pkg::S_IDLE;
      default: state_nxt = ptfl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = (state_r != ptfl_pkg::S_IDLE);
    case (state_r)
      ptfl_pkg::S_IDLE: begin
        ctrl.capture = start;
      end
      ptfl_pkg::S_CLEAR: ctrl.clear_step = 1'b1;
      ptfl_pkg::S_CHECK: begin
        ctrl.clear_start = stat.reinit;
        ctrl.err = !stat.reinit && stat.bad;
        ctrl.lookup = !stat.reinit && !stat.bad;
      end
      ptfl_pkg::S_LOOKUP: ctrl.scan_start = 1'b1;
      ptfl_pkg::S_SCAN: ctrl.scan_step = 1'b1;
      ptfl_pkg::S_EVICT_RD: ctrl.evict_rd = 1'b1;
      ptfl_pkg::S_EVICT_WR: ctrl.evict_wr = 1'b1;
      ptfl_pkg::S_LOAD: ctrl.load = 1'b1;
      ptfl_pkg::S_HIT: ctrl.hit = 1'b1;
      ptfl_pkg::S_DONE: ctrl.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/ptfl_dp.sv */
// Datapath for the paged translation unit: page table memory, frame table,
// victim scan, counters and result register. Depends on ptfl_pkg.
module ptfl_dp #(
  parameter int MAX_FRAMES = ptfl_pkg::MAX_FRAMES_DEF,
  parameter int MAX_PROCESSES = ptfl_pkg::MAX_PROCESSES_DEF,
  parameter int PAGES_PER_PROCESS = ptfl_pkg::PAGES_PER_PROCESS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptfl_pkg::in_req_t  in_req,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  ptfl_pkg::ctrl_t    ctrl,
  output ptfl_pkg::stat_t    stat,
  output logic               out_strobe,
  output ptfl_pkg::out_res_t out_res
);

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int PW = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int DEPTH = MAX_PROCESSES * PAGES_PER_PROCESS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  // config registers
  logic       mode_r;
  logic [3:0] psize_r, nfr_r, npr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; psize_r <= 4'd8; nfr_r <= 4'd8; npr_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        ptfl_pkg::CFG_MODE:   mode_r <= cfg_data[0];
        ptfl_pkg::CFG_PSIZE:  psize_r <= cfg_data;
        ptfl_pkg::CFG_FRAMES: nfr_r <= cfg_data;
        ptfl_pkg::CFG_PROCS:  npr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [3:0] shift;
  logic [6:0] nfr, npr;
  always_comb begin
    shift = (psize_r < 4'd4) ? 4'd4 : ((psize_r > 4'd12) ? 4'd12 : psize_r);
    nfr = (nfr_r == 4'd0) ? 7'd1 : {3'd0, nfr_r};
    if (nfr > 7'(MAX_FRAMES)) nfr = 7'(MAX_FRAMES);
    npr = (npr_r == 4'd0) ? 7'd1 : {3'd0, npr_r};
    if (npr > 7'(MAX_PROCESSES)) npr = 7'(MAX_PROCESSES);
  end

  // captured request
  ptfl_pkg::in_req_t req_r;
  always_ff @(posedge clk) if (ctrl.capture) req_r <= in_req;

  logic [15:0] page_w, offset;
  assign page_w = req_r.virtual_address >> shift;
  assign offset = req_r.virtual_address & ((16'd1 << shift) - 16'd1);
  logic [PW-1:0] page;
  assign page = PW'(page_w);
  logic bad_slot, bad_page;
  assign bad_slot = {4'd0, req_r.process_slot} >= npr;
  assign bad_page = {16'd0, page_w} >= 32'(PAGES_PER_PROCESS);
  logic [AW-1:0] idx;
  assign idx = AW'(32'(req_r.process_slot) * PAGES_PER_PROCESS + 32'(page));

  // page table memory: present bit and frame, zeroed by the clear sweep
  // after reset and after each reinitialise
  logic [FW:0] pt_mem [DEPTH];
  logic [FW:0] pt_rd_r;
  logic [AW-1:0] clr_addr_r;
  logic clr_busy_r;
  logic [AW-1:0] oidx_r;
  logic pt_we;
  logic [AW-1:0] pt_wa, pt_ra;
  logic [FW:0] pt_wd;

  // frame table
  logic          occ_r [MAX_FRAMES];
  logic [SW-1:0] oslot_r [MAX_FRAMES];
  logic [PW-1:0] opage_r [MAX_FRAMES];
  logic [31:0]   lt_r [MAX_FRAMES];
  logic [31:0]   ut_r [MAX_FRAMES];
  logic [31:0]   time_r, acc_r, flt_r;

  // scan
  logic [CW-1:0] scan_r;
  logic [FW-1:0] vic_r;
  logic [31:0]   best_r;
  logic          found_r, free_r;
  logic [FW-1:0] sf;
  assign sf = FW'(scan_r);
  logic [31:0] tsel;
  assign tsel = mode_r ? ut_r[sf] : lt_r[sf];

  always_comb begin
    pt_we = 1'b0; pt_wa = idx; pt_wd = {1'b1, vic_r}; pt_ra = idx;
    if (clr_busy_r) begin
      pt_we = 1'b1; pt_wa = clr_addr_r; pt_wd = '0;
    end else if (ctrl.evict_wr) begin
      pt_wa = oidx_r;
      pt_wd = '0;
      pt_we = pt_rd_r[FW] && (pt_rd_r[FW-1:0] == vic_r);
    end else if (ctrl.load) begin
      pt_we = 1'b1;
    end
    if (ctrl.evict_rd) pt_ra = oidx_r;
  end

  // page table memory port
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    pt_rd_r <= pt_mem[pt_ra];
  end

  // clear sweep over the page table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1; clr_addr_r <= '0;
    end else if (ctrl.clear_start) begin
      clr_busy_r <= 1'b1; clr_addr_r <= '0;
    end else if (clr_busy_r && ctrl.clear_step) begin
      if (32'(clr_addr_r) == DEPTH - 1) clr_busy_r <= 1'b0;
      else clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  logic [FW-1:0] fr;
  assign fr = ctrl.load ? vic_r : pt_rd_r[FW-1:0];

  // frame table, counters and scan
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_start) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        occ_r[i] <= 1'b0; oslot_r[i] <= '0; opage_r[i] <= '0; lt_r[i] <= '0; ut_r[i] <= '0;
      end
      time_r <= 32'd1; acc_r <= '0; flt_r <= '0;
    end else begin
      if (ctrl.lookup) acc_r <= (acc_r == '1) ? acc_r : acc_r + 32'd1;
      if (ctrl.load) begin
        flt_r <= (flt_r == '1) ? flt_r : flt_r + 32'd1;
        occ_r[vic_r] <= 1'b1;
        oslot_r[vic_r] <= SW'(req_r.process_slot);
        opage_r[vic_r] <= page;
        lt_r[vic_r] <= time_r;
      end
      if (ctrl.load || ctrl.hit) begin
        ut_r[fr] <= time_r;
        time_r <= (time_r == '1) ? time_r : time_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      scan_r <= '0; found_r <= 1'b0; free_r <= 1'b0; vic_r <= '0;
    end else if (ctrl.scan_step && !stat.scan_done) begin
      if (!occ_r[sf]) begin
        vic_r <= sf; free_r <= 1'b1;
      end else if (!found_r || tsel < best_r) begin
        vic_r <= sf; best_r <= tsel; found_r <= 1'b1;
      end
      scan_r <= scan_r + CW'(1);
    end
    if (ctrl.scan_step && stat.scan_done)
      oidx_r <= AW'(32'(oslot_r[vic_r]) * PAGES_PER_PROCESS + 32'(opage_r[vic_r]));
  end

  assign stat.reinit = (req_r.operation == ptfl_pkg::OP_REINIT);
  assign stat.bad = bad_slot || bad_page;
  assign stat.present = pt_rd_r[FW];
  assign stat.scan_done = free_r || (7'(scan_r) >= nfr);
  assign stat.clear_done = !clr_busy_r;
  assign stat.victim_occ = occ_r[vic_r];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= ctrl.finish || ctrl.clear_start;
    if (ctrl.clear_start) begin
      out_res <= '0;
    end else if (ctrl.err) begin
      out_res.physical_address <= '0; out_res.page_fault <= 1'b0;
      out_res.frame_number <= '0;
      out_res.status <= bad_slot ? ptfl_pkg::ST_BAD_SLOT : ptfl_pkg::ST_BAD_PAGE;
    end else if (ctrl.load || ctrl.hit) begin
      out_res.physical_address <= 15'((32'(fr) << shift) | 32'(offset));
      out_res.page_fault <= ctrl.load;
      out_res.frame_number <= 3'(fr);
      out_res.status <= ptfl_pkg::ST_OK;
    end
    if (ctrl.finish) begin
      out_res.accesses_so_far <= acc_r;
      out_res.faults_so_far <= flt_r;
    end
  end

`ifndef SYNTHESIS
  a_load_has_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> (free_r || found_r)) else $error("load without victim");
  a_no_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(ctrl.load || ctrl.hit)) else $error("access during clear");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");
`endif

endmodule

/* hw/rtl/paged_translation_fifo_lru_unit.sv */
// Top level of the paged translation unit with FIFO/LRU frame replacement.
// Depends on ptfl_pkg, ptfl_ctrl and ptfl_dp.
//
// A request is taken when start is high and busy low; one result follows,
// on out_strobe for a single cycle, and cannot be held off. A hit passes
// check, lookup, hit, done; a fault check, lookup, scan, evict read/write if
// the victim is occupied, load, done; an error check, done. The frame scan
// walks one frame per cycle. After reset and after each reinitialize request
// a sweep clears the page table one entry per cycle while busy is high.
module paged_translation_fifo_lru_unit #(
  parameter int MAX_FRAMES = ptfl_pkg::MAX_FRAMES_DEF,
  parameter int MAX_PROCESSES = ptfl_pkg::MAX_PROCESSES_DEF,
  parameter int PAGES_PER_PROCESS = ptfl_pkg::PAGES_PER_PROCESS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ptfl_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output ptfl_pkg::out_res_t out_res,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  ptfl_pkg::ctrl_t ctrl;
  ptfl_pkg::stat_t stat;

  ptfl_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .stat, .ctrl);

  ptfl_dp #(
    .MAX_FRAMES(MAX_FRAMES), .MAX_PROCESSES(MAX_PROCESSES),
    .PAGES_PER_PROCESS(PAGES_PER_PROCESS)
  ) u_dp (.clk, .rst_n, .in_req, .cfg_we, .cfg_index, .cfg_data, .ctrl, .stat,
          .out_strobe, .out_res);

endmodule
